// File: hw/rtl/tmc_pkg.sv
package tmc_pkg;

  // fixed field widths of the stream payload
  localparam int DATA_W   = 32;
  localparam int IN_IDX_W = 4;
  localparam int TDATA_W  = 40;

  // one multiply-accumulate step handed from the sequencer to the mac
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_issue_t;

  // control of the accumulated matrix store
  typedef struct packed {
    logic restart;
    logic swap;
  } acc_ctl_t;

endpackage

// File: hw/rtl/tmc_operand_store.sv
module tmc_operand_store #(
  parameter int  MATRIX_DIM = 4,
  localparam int ELEMS      = MATRIX_DIM * MATRIX_DIM,
  localparam int IDX_W      = $clog2(ELEMS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [tmc_pkg::DATA_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [tmc_pkg::DATA_W-1:0]  rd_data
);

  logic [tmc_pkg::DATA_W-1:0] mem_r [1 << IDX_W];
  logic [(1 << IDX_W)-1:0]    valid_r;
  logic [tmc_pkg::DATA_W-1:0] rd_data_r;
  logic                       rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// File: hw/rtl/tmc_accum_store.sv
module tmc_accum_store #(
  parameter int  MATRIX_DIM = 4,
  parameter int  FRAC_BITS  = 16,
  localparam int ELEMS      = MATRIX_DIM * MATRIX_DIM,
  localparam int IDX_W      = $clog2(ELEMS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tmc_pkg::acc_ctl_t           ctl,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            rd_addr,
  input  logic                        rd_diag,
  output logic [tmc_pkg::DATA_W-1:0]  rd_data,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [tmc_pkg::DATA_W-1:0]  wr_data
);

  localparam int BANK_DEPTH = 1 << IDX_W;
  localparam logic [tmc_pkg::DATA_W-1:0] ONE = tmc_pkg::DATA_W'(1) << FRAC_BITS;

  // two banks: reads from the current one, products go to the other
  logic [tmc_pkg::DATA_W-1:0] mem_r [2 * BANK_DEPTH];
  logic [2*BANK_DEPTH-1:0]    valid_r;
  logic                       bank_r;
  logic [tmc_pkg::DATA_W-1:0] rd_data_r;
  logic                       rd_valid_r;
  logic                       rd_diag_r;
  logic [IDX_W:0]             rd_loc;
  logic [IDX_W:0]             wr_loc;

  assign rd_loc = {bank_r, rd_addr};
  assign wr_loc = {~bank_r, wr_addr};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_loc] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_loc];
      rd_diag_r <= rd_diag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      bank_r     <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      // restart drops the current bank back to identity
      for (int i = 0; i < BANK_DEPTH; i++) begin
        if (ctl.restart) begin
          valid_r[{bank_r, IDX_W'(i)}] <= 1'b0;
        end
      end
      if (wr_en) begin
        valid_r[wr_loc] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_loc];
      end
      if (ctl.swap) begin
        bank_r <= ~bank_r;
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : (rd_diag_r ? ONE : '0);

endmodule

// File: hw/rtl/tmc_mac.sv
module tmc_mac #(
  parameter int MATRIX_DIM = 4,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tmc_pkg::mac_issue_t                issue,
  input  logic signed [tmc_pkg::DATA_W-1:0]  a,
  input  logic signed [tmc_pkg::DATA_W-1:0]  b,
  input  logic                               take,
  output logic                               idle,
  output logic                               done,
  output logic [tmc_pkg::DATA_W-1:0]         result
);

  localparam int DW    = tmc_pkg::DATA_W;
  localparam int ACC_W = 2 * DW + $clog2(MATRIX_DIM) + 1;

  tmc_pkg::mac_issue_t      s1_r;
  tmc_pkg::mac_issue_t      s2_r;
  logic                     done_r;
  logic signed [2*DW-1:0]   prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-DW:0]        hi;
  logic                     fits;

  // s1 lines up with the registered memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      s2_r   <= '0;
      done_r <= 1'b0;
    end else begin
      s1_r <= issue;
      s2_r <= s1_r;
      if (s2_r.valid && s2_r.last) begin
        done_r <= 1'b1;
      end else if (take) begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_r.valid) begin
      prod_r <= a * b;
    end
    if (s2_r.valid) begin
      acc_r <= s2_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  // arithmetic shift, then saturate to the signed data width
  assign shifted = acc_r >>> FRAC_BITS;
  assign hi      = shifted[ACC_W-1:DW-1];
  assign fits    = (&hi) || !(|hi);

  always_comb begin
    if (fits) begin
      result = shifted[DW-1:0];
    end else if (acc_r[ACC_W-1]) begin
      result = {1'b1, {(DW-1){1'b0}}};
    end else begin
      result = {1'b0, {(DW-1){1'b1}}};
    end
  end

  assign idle = !s1_r.valid && !s2_r.valid && !done_r;
  assign done = done_r;

endmodule

// File: hw/rtl/transform_matrix_compose_top.sv
// transform matrix composer: keeps an accumulated matrix a (identity after reset)
// and composes it with an operand matrix b, signed fixed point with FRAC_BITS
// fraction bits, all matrices column-major (index = col * MATRIX_DIM + row).
// input stream: each transfer writes one element of b; tlast on a transfer starts
// a = a * b after that element is stored; tuser[0] with tlast resets a to identity
// first. indexes beyond the matrix store nothing but tlast still counts.
// output stream: MATRIX_DIM * MATRIX_DIM transfers of the product in index order,
// tlast on the final one. values are full-width sums, shifted and saturated.
// multiply: product elements are worked one at a time. for each, one multiplier is
// fed one a and one b element per cycle from the two stores through two pipeline
// stages (product, then accumulator); the result is handed to the output register,
// and the next element starts only once the mac is idle again, so a stalled
// output also holds back the multiply. in_tready is low while a multiply runs. the
// output register holds a result while out_tready is low and the next element waits
// in the mac, nothing is dropped.
// reset: a returns to identity, b to zero, both streams empty.
module transform_matrix_compose_top #(
  parameter int MATRIX_DIM = 4,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [tmc_pkg::TDATA_W-1:0]  in_tdata,   // element_index[3:0], element_value[35:4]
  input  logic                         in_tlast,   // is_last
  input  logic [0:0]                   in_tuser,   // restart_identity[0]
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [tmc_pkg::TDATA_W-1:0]  out_tdata,  // result_index[3:0], result_value[35:4]
  output logic                         out_tlast   // result_last
);

  localparam int ELEMS = MATRIX_DIM * MATRIX_DIM;
  localparam int IDX_W = $clog2(ELEMS);
  localparam int DIM_W = $clog2(MATRIX_DIM);
  localparam int DW    = tmc_pkg::DATA_W;
  localparam int IW    = tmc_pkg::IN_IDX_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                 state_r;
  logic                 issuing_r;     // reads for one element going out
  logic                 all_issued_r;  // every element of the product started
  logic [DIM_W-1:0]     col_r;
  logic [DIM_W-1:0]     row_r;
  logic [DIM_W-1:0]     k_r;
  logic [IDX_W-1:0]     res_cnt_r;     // index of the next result to hand over
  logic                 out_valid_r;
  logic [IW-1:0]        out_idx_r;
  logic [DW-1:0]        out_value_r;
  logic                 out_last_r;

  logic                 in_accept;
  logic [IW-1:0]        in_idx;
  logic [DW-1:0]        in_value;
  logic [IDX_W+IW-1:0]  in_idx_ext;
  logic                 in_in_range;
  logic                 start;
  logic                 k_last;
  logic                 row_last;
  logic                 col_last;
  logic [IDX_W-1:0]     a_addr;
  logic [IDX_W-1:0]     b_addr;
  logic [DW-1:0]        a_data;
  logic [DW-1:0]        b_data;
  logic                 mac_idle;
  logic                 mac_done;
  logic [DW-1:0]        mac_result;
  logic                 take;
  logic                 res_last;
  logic [IDX_W+IW-1:0]  res_idx_ext;
  tmc_pkg::mac_issue_t  issue;
  tmc_pkg::acc_ctl_t    acc_ctl;

  // input side
  assign in_tready   = (state_r == ST_IDLE);
  assign in_accept   = in_tvalid && in_tready;
  assign in_idx      = in_tdata[IW-1:0];
  assign in_value    = in_tdata[IW+DW-1:IW];
  assign in_idx_ext  = {IDX_W'(0), in_idx};
  assign in_in_range = int'(in_idx) < ELEMS;
  assign start       = in_accept && in_tlast;

  // element sequencer: a(row, k) times b(k, col), k innermost
  assign k_last   = (k_r == DIM_W'(MATRIX_DIM - 1));
  assign row_last = (row_r == DIM_W'(MATRIX_DIM - 1));
  assign col_last = (col_r == DIM_W'(MATRIX_DIM - 1));
  assign a_addr   = IDX_W'(int'(k_r) * MATRIX_DIM + int'(row_r));
  assign b_addr   = IDX_W'(int'(col_r) * MATRIX_DIM + int'(k_r));

  assign issue.valid = issuing_r;
  assign issue.first = (k_r == '0);
  assign issue.last  = k_last;

  // a finished element moves to the output register when that is free
  assign take        = mac_done && (!out_valid_r || out_tready);
  assign res_last    = (res_cnt_r == IDX_W'(ELEMS - 1));
  assign res_idx_ext = {IW'(0), res_cnt_r};

  assign acc_ctl.restart = start && in_tuser[0];
  assign acc_ctl.swap    = take && res_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issuing_r    <= 1'b0;
      all_issued_r <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      k_r          <= '0;
      res_cnt_r    <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r      <= ST_RUN;
            issuing_r    <= 1'b1;
            all_issued_r <= 1'b0;
            col_r        <= '0;
            row_r        <= '0;
            k_r          <= '0;
            res_cnt_r    <= '0;
          end
        end
        ST_RUN: begin
          if (issuing_r) begin
            if (k_last) begin
              k_r       <= '0;
              issuing_r <= 1'b0;
              if (row_last) begin
                row_r <= '0;
                if (col_last) begin
                  all_issued_r <= 1'b1;
                end else begin
                  col_r <= col_r + DIM_W'(1);
                end
              end else begin
                row_r <= row_r + DIM_W'(1);
              end
            end else begin
              k_r <= k_r + DIM_W'(1);
            end
          end else if (!all_issued_r && mac_idle) begin
            issuing_r <= 1'b1;
          end
          if (take) begin
            res_cnt_r <= res_cnt_r + IDX_W'(1);
            if (res_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_idx_r   <= res_idx_ext[IW-1:0];
      out_value_r <= mac_result;
      out_last_r  <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(tmc_pkg::TDATA_W - IW - DW)'(0), out_value_r, out_idx_r};
  assign out_tlast  = out_last_r;

  // operand matrix b
  tmc_operand_store #(
    .MATRIX_DIM (MATRIX_DIM)
  ) u_operand_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_accept && in_in_range),
    .wr_addr (in_idx_ext[IDX_W-1:0]),
    .wr_data (in_value),
    .rd_en   (issuing_r),
    .rd_addr (b_addr),
    .rd_data (b_data)
  );

  // accumulated matrix a, products written into its spare bank
  tmc_accum_store #(
    .MATRIX_DIM (MATRIX_DIM),
    .FRAC_BITS  (FRAC_BITS)
  ) u_accum_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (acc_ctl),
    .rd_en   (issuing_r),
    .rd_addr (a_addr),
    .rd_diag (k_r == row_r),
    .rd_data (a_data),
    .wr_en   (take),
    .wr_addr (res_cnt_r),
    .wr_data (mac_result)
  );

  tmc_mac #(
    .MATRIX_DIM (MATRIX_DIM),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (issue),
    .a      (a_data),
    .b      (b_data),
    .take   (take),
    .idle   (mac_idle),
    .done   (mac_done),
    .result (mac_result)
  );

endmodule
